// ----- rtl/core/adkf_pkg.sv -----
package adkf_pkg;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_DEL    = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_DECIDE = 2'd3;

    // list codes
    localparam logic [1:0] LST_DENY_OBJ  = 2'd0;
    localparam logic [1:0] LST_DENY_OWN  = 2'd1;
    localparam logic [1:0] LST_ALLOW_OBJ = 2'd2;
    localparam logic [1:0] LST_ALLOW_OWN = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EXISTS   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // one table slot as stored in the memory
    typedef struct packed {
        logic        valid;
        logic [1:0]  lst;
        logic [31:0] dev;
        logic [63:0] ino;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ----- rtl/core/adkf_ram.sv -----
module adkf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/allow_deny_key_filter_table.sv -----
// Key filter table with four lists (deny object, deny owner, allow object,
// allow owner) sharing ENTRIES slots in one single-port-read memory. Every
// request (add, delete, query, decide) walks the whole table one slot per
// cycle through the memory read port; a new request is accepted only once
// the result of the last one has been moved into an output register, where it
// sits until taken, while the next item may already be accepted. After reset
// the block sweeps every slot of the memory to mark all slots free and holds
// o_ready low during that sweep.
module allow_deny_key_filter_table #(
    parameter int ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_list_sel,
    input  logic [31:0] i_key_dev,
    input  logic [63:0] i_key_ino,
    input  logic [31:0] i_exe_dev,
    input  logic [63:0] i_exe_ino,
    input  logic        i_has_exe,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_hit
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // request registers
    logic [1:0]  r_req;
    logic [1:0]  r_lst;
    logic [31:0] r_kdev;
    logic [63:0] r_kino;
    logic [31:0] r_edev;
    logic [63:0] r_eino;
    logic        r_has_exe;

    // scan control
    logic [AW-1:0] r_addr;
    logic          r_issue;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;

    // scan findings
    logic          r_free_found;
    logic [AW-1:0] r_free_idx;
    logic          r_key_found;
    logic [AW-1:0] r_key_idx;
    logic          r_hit_dobj, r_hit_down, r_hit_aobj, r_hit_aown;
    logic          r_seen_aobj, r_seen_aown;

    // output register
    logic       r_out_valid;
    logic [1:0] r_status;
    logic       r_hit;

    // memory signals
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    adkf_pkg::t_entry            w_wentry;
    logic [adkf_pkg::ENTRY_W-1:0] w_rdata;
    adkf_pkg::t_entry            w_rentry;
    logic                        w_re;

    logic w_accept;
    logic w_finish;
    logic w_owner_lst;
    logic w_kmatch, w_ematch;
    logic w_do_write;
    logic [1:0] w_status;
    logic w_hit;

    assign w_accept    = i_valid && o_ready;
    assign w_finish    = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign w_owner_lst = (r_lst == adkf_pkg::LST_DENY_OWN) ||
                         (r_lst == adkf_pkg::LST_ALLOW_OWN);

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_hit    = r_hit;

    // table memory
    assign w_re     = (r_state == S_SCAN) && r_issue;
    assign w_rentry = adkf_pkg::t_entry'(w_rdata);

    adkf_ram #(
        .WIDTH (adkf_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // key compares against the slot being read
    assign w_kmatch = (w_rentry.dev == r_kdev) && (w_rentry.ino == r_kino);
    assign w_ematch = (w_rentry.dev == r_edev) && (w_rentry.ino == r_eino);

    // result and write-back decision at end of scan
    always_comb begin
        w_status   = adkf_pkg::ST_OK;
        w_hit      = 1'b0;
        w_do_write = 1'b0;
        unique case (r_req)
            adkf_pkg::REQ_ADD: begin
                if (!r_free_found) begin
                    w_status = adkf_pkg::ST_FULL;
                end else if (w_owner_lst && r_key_found) begin
                    w_status = adkf_pkg::ST_EXISTS;
                end else begin
                    w_do_write = 1'b1;
                end
            end
            adkf_pkg::REQ_DEL: begin
                if (!r_key_found) begin
                    w_status = adkf_pkg::ST_NOTFOUND;
                end else begin
                    w_do_write = 1'b1;
                end
            end
            adkf_pkg::REQ_QUERY: begin
                w_hit = r_key_found && !(w_owner_lst && !r_has_exe);
            end
            default: begin
                w_hit = !(r_hit_dobj ||
                          (r_has_exe && r_hit_down) ||
                          (r_seen_aobj && !r_hit_aobj) ||
                          (r_has_exe && r_seen_aown && !r_hit_aown));
            end
        endcase
    end

    // write port: clearing sweep or request write-back
    always_comb begin
        w_wentry = '0;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_addr;
        end else begin
            w_we    = w_finish && w_do_write;
            w_waddr = (r_req == adkf_pkg::REQ_ADD) ? r_free_idx : r_key_idx;
            if (r_req == adkf_pkg::REQ_ADD) begin
                w_wentry.valid = 1'b1;
                w_wentry.lst   = r_lst;
                w_wentry.dev   = r_kdev;
                w_wentry.ino   = r_kino;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_addr == LAST_IDX) n_state = S_IDLE;
            S_IDLE:  if (w_accept) n_state = S_SCAN;
            S_SCAN:  if (r_rd_vld && (r_rd_idx == LAST_IDX)) n_state = S_DONE;
            S_DONE:  if (w_finish) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_re;
            if (r_state == S_CLEAR) begin
                r_addr <= r_addr + 1'b1;
            end else if (w_accept) begin
                r_addr  <= '0;
                r_issue <= 1'b1;
            end else if (w_re) begin
                r_addr <= r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    r_issue <= 1'b0;
                end
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and scan findings
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (w_accept) begin
            r_req        <= i_req_type;
            r_lst        <= i_list_sel;
            r_kdev       <= i_key_dev;
            r_kino       <= i_key_ino;
            r_edev       <= i_exe_dev;
            r_eino       <= i_exe_ino;
            r_has_exe    <= i_has_exe;
            r_free_found <= 1'b0;
            r_key_found  <= 1'b0;
            r_hit_dobj   <= 1'b0;
            r_hit_down   <= 1'b0;
            r_hit_aobj   <= 1'b0;
            r_hit_aown   <= 1'b0;
            r_seen_aobj  <= 1'b0;
            r_seen_aown  <= 1'b0;
        end else if (r_rd_vld) begin
            if (!w_rentry.valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
            if (w_rentry.valid && (w_rentry.lst == r_lst) && w_kmatch && !r_key_found) begin
                r_key_found <= 1'b1;
                r_key_idx   <= r_rd_idx;
            end
            if (w_rentry.valid) begin
                case (w_rentry.lst)
                    adkf_pkg::LST_DENY_OBJ: begin
                        if (w_kmatch) r_hit_dobj <= 1'b1;
                    end
                    adkf_pkg::LST_DENY_OWN: begin
                        if (w_ematch) r_hit_down <= 1'b1;
                    end
                    adkf_pkg::LST_ALLOW_OBJ: begin
                        r_seen_aobj <= 1'b1;
                        if (w_kmatch) r_hit_aobj <= 1'b1;
                    end
                    default: begin
                        r_seen_aown <= 1'b1;
                        if (w_ematch) r_hit_aown <= 1'b1;
                    end
                endcase
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_status <= w_status;
            r_hit    <= w_hit;
        end
    end

endmodule

// ----- rtl/core/adkf_checker.sv -----
module adkf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic        o_hit
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_hit))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an accepted item");

    // a hit only comes with an ok status
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_status == adkf_pkg::ST_OK)
        else $error("hit with a non-ok status");

    // a new result only appears at the end of a scan
    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared while idle");

endmodule

bind allow_deny_key_filter_table adkf_checker u_adkf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_status   (o_status),
    .o_hit      (o_hit)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

// one request item as driven on the input ports
typedef struct packed {
    logic [1:0]  req;
    logic [1:0]  lst;
    logic [31:0] dev;
    logic [63:0] ino;
    logic [31:0] exe_dev;
    logic [63:0] exe_ino;
    logic        has_exe;
} t_request;

// one result item
typedef struct packed {
    logic [1:0] status;
    logic       hit;
} t_outcome;

// mirror of the key table plus the queue of outcomes still to come
class filter_table_checker #(int SLOTS = 64);
    bit          slot_used [SLOTS];
    logic [1:0]  slot_list [SLOTS];
    logic [31:0] slot_dev  [SLOTS];
    logic [63:0] slot_ino  [SLOTS];
    int unsigned list_size [4];
    t_outcome    outcome_q [$];

    int errors     = 0;
    int checked    = 0;
    int n_full     = 0;
    int n_exists   = 0;
    int n_notfound = 0;
    int n_accept   = 0;
    int n_reject   = 0;

    function new();
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
        end
        for (int l = 0; l < 4; l++) begin
            list_size[l] = 0;
        end
    endfunction

    // lowest used slot in list lst holding the key, or -1
    function int find_slot(logic [1:0] lst, logic [31:0] dev, logic [63:0] ino);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_list[i] == lst && slot_dev[i] == dev &&
                slot_ino[i] == ino)
                return i;
        end
        return -1;
    endfunction

    function int free_slot();
        for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i])
                return i;
        end
        return -1;
    endfunction

    function int occupancy();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i])
                n++;
        end
        return n;
    endfunction

    // some used slot at or after start (wrapping), or -1 if the table is empty
    function int used_slot_from(int start);
        int k;
        for (int i = 0; i < SLOTS; i++) begin
            k = (start + i) % SLOTS;
            if (slot_used[k])
                return k;
        end
        return -1;
    endfunction

    function int pending();
        return outcome_q.size();
    endfunction

    // apply one accepted request to the mirror and queue its outcome
    function void note_request(t_request r);
        t_outcome o;
        int       idx;
        bit       owner_lst;
        bit       accept;
        o.status  = adkf_pkg::ST_OK;
        o.hit     = 1'b0;
        owner_lst = (r.lst == adkf_pkg::LST_DENY_OWN) || (r.lst == adkf_pkg::LST_ALLOW_OWN);
        case (r.req)
            adkf_pkg::REQ_ADD: begin
                idx = free_slot();
                if (idx < 0) begin
                    o.status = adkf_pkg::ST_FULL;
                    n_full++;
                end else if (owner_lst && find_slot(r.lst, r.dev, r.ino) >= 0) begin
                    o.status = adkf_pkg::ST_EXISTS;
                    n_exists++;
                end else begin
                    slot_used[idx] = 1'b1;
                    slot_list[idx] = r.lst;
                    slot_dev[idx]  = r.dev;
                    slot_ino[idx]  = r.ino;
                    list_size[r.lst]++;
                end
            end
            adkf_pkg::REQ_DEL: begin
                idx = find_slot(r.lst, r.dev, r.ino);
                if (idx < 0) begin
                    o.status = adkf_pkg::ST_NOTFOUND;
                    n_notfound++;
                end else begin
                    slot_used[idx] = 1'b0;
                    if (list_size[r.lst] > 0)
                        list_size[r.lst]--;
                end
            end
            adkf_pkg::REQ_QUERY: begin
                // owner lists never match without an owner key
                if (owner_lst && !r.has_exe)
                    o.hit = 1'b0;
                else
                    o.hit = (find_slot(r.lst, r.dev, r.ino) >= 0);
            end
            default: begin
                accept = 1'b1;
                if (find_slot(adkf_pkg::LST_DENY_OBJ, r.dev, r.ino) >= 0)
                    accept = 1'b0;
                else if (r.has_exe &&
                         find_slot(adkf_pkg::LST_DENY_OWN, r.exe_dev, r.exe_ino) >= 0)
                    accept = 1'b0;
                else if (list_size[adkf_pkg::LST_ALLOW_OBJ] != 0 &&
                         find_slot(adkf_pkg::LST_ALLOW_OBJ, r.dev, r.ino) < 0)
                    accept = 1'b0;
                else if (r.has_exe && list_size[adkf_pkg::LST_ALLOW_OWN] != 0 &&
                         find_slot(adkf_pkg::LST_ALLOW_OWN, r.exe_dev, r.exe_ino) < 0)
                    accept = 1'b0;
                o.hit = accept;
                if (accept)
                    n_accept++;
                else
                    n_reject++;
            end
        endcase
        outcome_q.push_back(o);
    endfunction

    // compare one accepted result with the oldest outcome
    function void check_result(logic [1:0] status, logic hit);
        t_outcome o;
        checked++;
        if (outcome_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: result status %0d hit %0d with no item waiting",
                         status, hit);
            return;
        end
        o = outcome_q.pop_front();
        if (status !== o.status || hit !== o.hit) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected status %0d hit %0d, got status %0d hit %0d",
                         o.status, o.hit, status, hit);
        end
    endfunction
endclass

module testbench;
    import adkf_pkg::*;

    localparam int TABLE_SLOTS  = 64;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = TABLE_SLOTS + 16;
    localparam int POOL_KEYS    = 8;
    localparam int MIXED_ITEMS  = 45;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [1:0]  i_req_type = '0;
    logic [1:0]  i_list_sel = '0;
    logic [31:0] i_key_dev  = '0;
    logic [63:0] i_key_ino  = '0;
    logic [31:0] i_exe_dev  = '0;
    logic [63:0] i_exe_ino  = '0;
    logic        i_has_exe  = 1'b0;
    logic        i_ready    = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_hit;

    filter_table_checker #(TABLE_SLOTS) filter_sb;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;
    bit tx_up        = 1'b0;

    logic [31:0] pool_dev [POOL_KEYS];
    logic [63:0] pool_ino [POOL_KEYS];

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    allow_deny_key_filter_table #(
        .ENTRIES(TABLE_SLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_list_sel (i_list_sel),
        .i_key_dev  (i_key_dev),
        .i_key_ino  (i_key_ino),
        .i_exe_dev  (i_exe_dev),
        .i_exe_ino  (i_exe_ino),
        .i_has_exe  (i_has_exe),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_hit      (o_hit)
    );

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            filter_sb.check_result(o_status, o_hit);
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_request make_req(logic [1:0] req, logic [1:0] lst,
                                          logic [31:0] dev, logic [63:0] ino,
                                          logic [31:0] edev, logic [63:0] eino,
                                          logic he);
        t_request r;
        r.req     = req;
        r.lst     = lst;
        r.dev     = dev;
        r.ino     = ino;
        r.exe_dev = edev;
        r.exe_ino = eino;
        r.has_exe = he;
        return r;
    endfunction

    // key from a stored slot, the small pool or fully random
    function automatic void pick_key(int stored_pct, output logic [31:0] dev,
                                     output logic [63:0] ino, output int slot);
        int p;
        int k;
        p    = $urandom_range(99);
        slot = -1;
        if (p < stored_pct)
            slot = filter_sb.used_slot_from($urandom_range(TABLE_SLOTS - 1));
        if (slot >= 0) begin
            dev = filter_sb.slot_dev[slot];
            ino = filter_sb.slot_ino[slot];
        end else if (p < stored_pct + 35) begin
            k   = $urandom_range(POOL_KEYS - 1);
            dev = pool_dev[k];
            ino = pool_ino[k];
        end else begin
            dev = $urandom;
            ino = {$urandom, $urandom};
        end
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       p;
        int       slot;
        int       eslot;
        p = $urandom_range(99);
        if (p < 30)
            r.req = REQ_ADD;
        else if (p < 55)
            r.req = REQ_DEL;
        else if (p < 75)
            r.req = REQ_QUERY;
        else
            r.req = REQ_DECIDE;
        r.lst     = 2'($urandom_range(3));
        r.has_exe = 1'($urandom_range(1));
        pick_key(45, r.dev, r.ino, slot);
        pick_key(45, r.exe_dev, r.exe_ino, eslot);
        // mostly aim deletes, queries and decides at the list the key lives in
        if (slot >= 0 && r.req != REQ_ADD && $urandom_range(99) < 70)
            r.lst = filter_sb.slot_list[slot];
        return r;
    endfunction

    task automatic send_item(t_request r);
        i_req_type <= r.req;
        i_list_sel <= r.lst;
        i_key_dev  <= r.dev;
        i_key_ino  <= r.ino;
        i_exe_dev  <= r.exe_dev;
        i_exe_ino  <= r.exe_ino;
        i_has_exe  <= r.has_exe;
        if (!tx_up)
            i_valid <= 1'b1;
        tx_up = 1'b1;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        filter_sb.note_request(r);
        items_sent++;
        // sender gap after the item
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            tx_up = 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // hold the sender off until every outcome has come back
    task automatic wait_all_results();
        if (tx_up) begin
            i_valid <= 1'b0;
            tx_up = 1'b0;
        end
        do @(posedge i_clk); while (filter_sb.pending() != 0);
    endtask

    task automatic run_directed();
        logic [31:0] ones_dev;
        logic [63:0] ones_ino;
        ones_dev = '1;
        ones_ino = '1;
        // empty table
        send_item(make_req(REQ_QUERY, LST_DENY_OBJ, pool_dev[5], pool_ino[5], '0, '0, 1'b1));
        send_item(make_req(REQ_DECIDE, LST_ALLOW_OWN, pool_dev[5], pool_ino[5],
                           ones_dev, ones_ino, 1'b1));
        // owner list duplicates and the missing owner case
        send_item(make_req(REQ_ADD, LST_DENY_OWN, ones_dev, ones_ino, '0, '0, 1'b0));
        send_item(make_req(REQ_ADD, LST_DENY_OWN, ones_dev, ones_ino, ones_dev, ones_ino, 1'b1));
        send_item(make_req(REQ_QUERY, LST_DENY_OWN, ones_dev, ones_ino, '0, '0, 1'b0));
        send_item(make_req(REQ_QUERY, LST_DENY_OWN, ones_dev, ones_ino, '0, '0, 1'b1));
        send_item(make_req(REQ_DECIDE, LST_DENY_OBJ, pool_dev[5], pool_ino[5],
                           ones_dev, ones_ino, 1'b1));
        send_item(make_req(REQ_DECIDE, LST_DENY_OBJ, pool_dev[5], pool_ino[5],
                           ones_dev, ones_ino, 1'b0));
        // object list duplicates and allow-object miss
        send_item(make_req(REQ_ADD, LST_ALLOW_OBJ, '0, '0, ones_dev, ones_ino, 1'b1));
        send_item(make_req(REQ_ADD, LST_ALLOW_OBJ, '0, '0, '0, '0, 1'b0));
        send_item(make_req(REQ_DECIDE, LST_ALLOW_OBJ, pool_dev[5], pool_ino[5],
                           '0, '0, 1'b0));
        send_item(make_req(REQ_DECIDE, LST_ALLOW_OBJ, '0, '0, pool_dev[6], pool_ino[6], 1'b0));
        // allow-owner miss and hit
        send_item(make_req(REQ_ADD, LST_ALLOW_OWN, pool_dev[6], pool_ino[6], '0, '0, 1'b1));
        send_item(make_req(REQ_DECIDE, LST_ALLOW_OWN, '0, '0, pool_dev[7], pool_ino[7], 1'b1));
        send_item(make_req(REQ_DECIDE, LST_ALLOW_OWN, '0, '0, pool_dev[6], pool_ino[6], 1'b1));
        send_item(make_req(REQ_DECIDE, LST_ALLOW_OWN, '0, '0, pool_dev[7], pool_ino[7], 1'b0));
        // deny-object hit overrides the allow lists
        send_item(make_req(REQ_ADD, LST_DENY_OBJ, '0, '0, '0, '0, 1'b0));
        send_item(make_req(REQ_DECIDE, LST_DENY_OBJ, '0, '0, pool_dev[6], pool_ino[6], 1'b1));
        // deletes: hit, miss, one of two duplicates, wrong list, partial key match
        send_item(make_req(REQ_DEL, LST_DENY_OBJ, '0, '0, '0, '0, 1'b0));
        send_item(make_req(REQ_DEL, LST_DENY_OBJ, '0, '0, '0, '0, 1'b0));
        send_item(make_req(REQ_DEL, LST_ALLOW_OBJ, '0, '0, ones_dev, ones_ino, 1'b1));
        send_item(make_req(REQ_QUERY, LST_ALLOW_OBJ, '0, '0, '0, '0, 1'b0));
        send_item(make_req(REQ_DEL, LST_ALLOW_OBJ, pool_dev[6], pool_ino[6], '0, '0, 1'b0));
        send_item(make_req(REQ_DEL, LST_DENY_OWN, ones_dev, '0, '0, '0, 1'b1));
        send_item(make_req(REQ_QUERY, LST_ALLOW_OWN, pool_dev[6], pool_ino[6],
                           ones_dev, ones_ino, 1'b1));
    endtask

    // fill the table to the brim, poke it while full, then empty most of it
    task automatic fill_and_drain();
        t_request r;
        int       slot;
        while (filter_sb.occupancy() < TABLE_SLOTS) begin
            r     = random_request();
            r.req = REQ_ADD;
            if ($urandom_range(99) < 70) begin
                r.dev = $urandom;
                r.ino = {$urandom, $urandom};
            end
            send_item(r);
        end
        repeat (4) begin
            r     = random_request();
            r.req = REQ_ADD;
            send_item(r);
        end
        repeat (3) begin
            r     = random_request();
            r.req = ($urandom_range(1) != 0) ? REQ_QUERY : REQ_DECIDE;
            send_item(r);
        end
        repeat (40) begin
            r     = random_request();
            r.req = REQ_DEL;
            slot  = filter_sb.used_slot_from($urandom_range(TABLE_SLOTS - 1));
            if (slot >= 0) begin
                r.lst = filter_sb.slot_list[slot];
                r.dev = filter_sb.slot_dev[slot];
                r.ino = filter_sb.slot_ino[slot];
            end
            send_item(r);
        end
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, bit with_directed);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (with_directed) begin
            run_directed();
            wait_all_results();
        end
        repeat (MIXED_ITEMS) send_item(random_request());
        fill_and_drain();
        repeat (MIXED_ITEMS) send_item(random_request());
        wait_all_results();
    endtask

    // main sequence
    initial begin
        filter_sb = new();
        pool_dev[0] = '0;
        pool_ino[0] = '0;
        pool_dev[1] = '1;
        pool_ino[1] = '1;
        for (int k = 2; k < POOL_KEYS; k++) begin
            pool_dev[k] = $urandom;
            pool_ino[k] = {$urandom, $urandom};
        end
        // keys that share only one half with another pool key
        pool_dev[3] = pool_dev[2];
        pool_ino[4] = pool_ino[2];

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_phase(38, 78, 1'b1);
        run_phase(78, 38, 1'b0);
        run_phase(0, 0, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d requests, %0d results checked, %0d failures, %0d missing",
                 items_sent, filter_sb.checked, filter_sb.errors, filter_sb.pending());
        $display("summary: full %0d, duplicate %0d, not found %0d, accept %0d, reject %0d",
                 filter_sb.n_full, filter_sb.n_exists, filter_sb.n_notfound,
                 filter_sb.n_accept, filter_sb.n_reject);
        if (filter_sb.errors == 0 && filter_sb.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/adkf_pkg.sv
rtl/core/adkf_ram.sv
rtl/core/allow_deny_key_filter_table.sv
rtl/core/adkf_checker.sv
bench/testbench.sv
